[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on the rising clock edge, off while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");

// concurrent assertion on the rising clock edge that also holds through reset
`define ASSERT_CLK_NR(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("assertion failed");

`endif

[design/utf8pe_pkg.sv]
`timescale 1ns / 1ps

package utf8pe_pkg;

   localparam int DefaultQueueDepth = 4;

   localparam logic [7:0] CharPercent = 8'h25;
   localparam logic [7:0] CharNul     = 8'h00;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        last_unit;
   } req_item_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       is_error;
      logic       run_end;
   } rsp_item_type;

   // one code point worth of work: utf-8 bytes in send order, or one error
   typedef struct packed {
      logic [3:0][7:0] bytes;
      logic [1:0]      last_idx;
      logic            is_error;
   } job_type;

   function automatic logic is_safe_byte(input logic [7:0] b);
      logic res;
      res = (b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
            (b >= 8'h30 && b <= 8'h39) || b == 8'h2e || b == 8'h2d ||
            b == 8'h5f || b == 8'h2f;
      return res;
   endfunction

   function automatic logic [7:0] hex_char(input logic [3:0] v);
      logic [7:0] res;
      if (v < 4'd10) begin
         res = 8'h30 + {4'b0, v};
      end else begin
         res = 8'h57 + {4'b0, v};
      end
      return res;
   endfunction

endpackage

[design/utf8pe_front.sv]
`timescale 1ns / 1ps

module utf8pe_front (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   input  utf8pe_pkg::req_item_type req_item,
   output logic                    req_full,
   input  logic                    q_full,
   output logic                    q_push,
   output utf8pe_pkg::job_type     q_job
);
   import utf8pe_pkg::*;

   logic [9:0]  pending_ff, pending_in;
   logic        have_pending_ff, have_pending_in;
   logic        discarding_ff, discarding_in;

   logic        accept;
   logic        is_low, is_high;
   logic        emit_cp, emit_err;
   logic [20:0] cp;

   assign req_full = q_full;
   assign accept   = req_push && !q_full;
   assign is_low   = req_item.code_unit[15:10] == 6'b110111;
   assign is_high  = req_item.code_unit[15:10] == 6'b110110;

   always_comb begin
      pending_in      = pending_ff;
      have_pending_in = have_pending_ff;
      discarding_in   = discarding_ff;
      emit_cp         = 1'b0;
      emit_err        = 1'b0;
      cp              = {5'b0, req_item.code_unit};
      if (!discarding_ff) begin
         if (have_pending_ff) begin
            if (is_low) begin
               cp      = {1'b0, pending_ff, req_item.code_unit[9:0]} + 21'h10000;
               emit_cp = 1'b1;
            end else begin
               emit_err      = 1'b1;
               discarding_in = 1'b1;
            end
            have_pending_in = 1'b0;
            pending_in      = '0;
         end else if (req_item.code_unit == 16'h0000) begin
            discarding_in = 1'b1;
         end else if (is_low) begin
            emit_err      = 1'b1;
            discarding_in = 1'b1;
         end else if (is_high) begin
            if (req_item.last_unit) begin
               emit_err = 1'b1;
            end else begin
               pending_in      = req_item.code_unit[9:0];
               have_pending_in = 1'b1;
            end
         end else begin
            emit_cp = 1'b1;
         end
      end
      // end of string puts everything back to the idle state
      if (req_item.last_unit) begin
         pending_in      = '0;
         have_pending_in = 1'b0;
         discarding_in   = 1'b0;
      end
   end

   // utf-8 byte split
   always_comb begin
      q_job          = '0;
      q_job.is_error = emit_err;
      if (cp < 21'h80) begin
         q_job.bytes[0] = {1'b0, cp[6:0]};
         q_job.last_idx = 2'd0;
      end else if (cp < 21'h800) begin
         q_job.bytes[0] = {3'b110, cp[10:6]};
         q_job.bytes[1] = {2'b10, cp[5:0]};
         q_job.last_idx = 2'd1;
      end else if (cp < 21'h10000) begin
         q_job.bytes[0] = {4'b1110, cp[15:12]};
         q_job.bytes[1] = {2'b10, cp[11:6]};
         q_job.bytes[2] = {2'b10, cp[5:0]};
         q_job.last_idx = 2'd2;
      end else begin
         q_job.bytes[0] = {5'b11110, cp[20:18]};
         q_job.bytes[1] = {2'b10, cp[17:12]};
         q_job.bytes[2] = {2'b10, cp[11:6]};
         q_job.bytes[3] = {2'b10, cp[5:0]};
         q_job.last_idx = 2'd3;
      end
      if (emit_err) begin
         q_job.last_idx = 2'd0;
      end
   end

   assign q_push = accept && (emit_cp || emit_err);

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff      <= '0;
         have_pending_ff <= 1'b0;
         discarding_ff   <= 1'b0;
      end else if (accept) begin
         pending_ff      <= pending_in;
         have_pending_ff <= have_pending_in;
         discarding_ff   <= discarding_in;
      end
   end

endmodule

[design/utf8pe_queue.sv]
`timescale 1ns / 1ps

module utf8pe_queue #(
   parameter int Depth = utf8pe_pkg::DefaultQueueDepth
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  utf8pe_pkg::job_type push_data,
   output logic                full,
   input  logic                pop,
   output utf8pe_pkg::job_type pop_data,
   output logic                empty
);
   import utf8pe_pkg::*;

   localparam int PtrWidth   = $clog2(Depth);
   localparam int CountWidth = $clog2(Depth + 1);

   job_type               entries_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  do_push, do_pop;

   assign full     = count_ff == CountWidth'(Depth);
   assign empty    = count_ff == '0;
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/utf8pe_back.sv]
`timescale 1ns / 1ps

module utf8pe_back (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     q_empty,
   input  utf8pe_pkg::job_type      q_job,
   output logic                     q_pop,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output utf8pe_pkg::rsp_item_type rsp_item
);
   import utf8pe_pkg::*;

   typedef enum logic [2:0] {
      PH_FIRST = 3'b001,
      PH_HI    = 3'b010,
      PH_LO    = 3'b100
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic         job_valid_ff, job_valid_in;
   job_type      job_ff, job_in;
   logic [1:0]   idx_ff, idx_in;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_ff, out_in;

   logic         can_emit, byte_done, job_done;
   logic [7:0]   cur_byte;
   rsp_item_type char_item;

   assign cur_byte = job_ff.bytes[idx_ff];
   assign can_emit = job_valid_ff && (!out_valid_ff || rsp_pop);

   always_comb begin
      char_item = '0;
      byte_done = 1'b0;
      if (job_ff.is_error) begin
         char_item.out_char = CharNul;
         char_item.is_error = 1'b1;
         byte_done          = 1'b1;
      end else begin
         unique case (phase_ff)
            PH_FIRST: begin
               if (is_safe_byte(cur_byte)) begin
                  char_item.out_char = cur_byte;
                  byte_done          = 1'b1;
               end else begin
                  char_item.out_char = CharPercent;
               end
            end
            PH_HI: begin
               char_item.out_char = hex_char(cur_byte[7:4]);
            end
            PH_LO: begin
               char_item.out_char = hex_char(cur_byte[3:0]);
               byte_done          = 1'b1;
            end
            default: begin
               char_item.out_char = CharNul;
            end
         endcase
      end
      job_done          = byte_done && (idx_ff == job_ff.last_idx);
      char_item.run_end = job_done;
   end

   assign q_pop = !q_empty && (!job_valid_ff || (can_emit && job_done));

   always_comb begin
      phase_in     = phase_ff;
      idx_in       = idx_ff;
      job_valid_in = job_valid_ff;
      job_in       = job_ff;
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (can_emit) begin
         out_valid_in = 1'b1;
         out_in       = char_item;
         if (job_done) begin
            job_valid_in = 1'b0;
            idx_in       = '0;
            phase_in     = PH_FIRST;
         end else if (byte_done) begin
            idx_in   = idx_ff + 1'b1;
            phase_in = PH_FIRST;
         end else begin
            phase_in = (phase_ff == PH_FIRST) ? PH_HI : PH_LO;
         end
      end else if (out_valid_ff && rsp_pop) begin
         out_valid_in = 1'b0;
      end
      if (q_pop) begin
         job_in       = q_job;
         job_valid_in = 1'b1;
         idx_in       = '0;
         phase_in     = PH_FIRST;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_FIRST;
         idx_ff       <= '0;
         job_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         idx_ff       <= idx_in;
         job_valid_ff <= job_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      job_ff <= job_in;
      out_ff <= out_in;
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_ff;

endmodule

[design/utf16_to_utf8_percent_encoder.sv]
`timescale 1ns / 1ps
// channel   | direction | handshake            | payload
// req_      | in        | req_push / req_full  | req_item  (code_unit, last_unit)
// rsp_      | out       | rsp_empty / rsp_pop  | rsp_item  (out_char, is_error, run_end)
//
// the front takes one item per cycle while the job queue has room; items
// that give no result (held high surrogate, zero unit, discarded units) take no queue entry
// the back sends one character per cycle while the output register is free or popped; an item
// gives 1 character for a literal or error, 3 per escaped byte, up to 12 for a 4-byte code point
// reset (synchronous, high) empties the queue and the output register
// either side may stall; the job queue and the output register keep the other side moving

module utf16_to_utf8_percent_encoder #(
   parameter int QueueDepth = utf8pe_pkg::DefaultQueueDepth
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_push,
   input  utf8pe_pkg::req_item_type req_item,
   output logic                     req_full,
   output logic                     rsp_empty,
   input  logic                     rsp_pop,
   output utf8pe_pkg::rsp_item_type rsp_item
);
   import utf8pe_pkg::*;

   // front to queue
   logic    q_push;
   logic    q_full;
   job_type q_wr_job;

   // queue to back
   logic    q_pop;
   logic    q_empty;
   job_type q_rd_job;

   // surrogate joining, string state and utf-8 byte split
   utf8pe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .req_full (req_full),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_job    (q_wr_job)
   );

   // short job queue between the two halves
   utf8pe_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wr_job),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rd_job),
      .empty     (q_empty)
   );

   // percent escaping, one character per cycle into the output register while it is free or popped
   utf8pe_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_job     (q_rd_job),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

[design/utf8pe_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8pe_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     req_full,
   input logic                     rsp_empty,
   input logic                     rsp_pop,
   input utf8pe_pkg::rsp_item_type rsp_item
);
   import utf8pe_pkg::*;

   logic rsp_waiting;
   logic rsp_err;
   logic pct_taken;
   logic hex_shown;

   assign rsp_waiting = !rsp_empty && !rsp_pop;
   assign rsp_err     = !rsp_empty && rsp_item.is_error;
   assign pct_taken   = !rsp_empty && rsp_pop && !rsp_item.is_error &&
                        rsp_item.out_char == CharPercent;
   assign hex_shown   = !rsp_item.is_error &&
                        ((rsp_item.out_char >= 8'h30 && rsp_item.out_char <= 8'h39) ||
                         (rsp_item.out_char >= 8'h61 && rsp_item.out_char <= 8'h66));

   // a waiting result is held until taken
   `ASSERT_CLK(rsp_hold, clock, reset, rsp_waiting |=> !rsp_empty && $stable(rsp_item))

   // reset leaves nothing queued on either side
   `ASSERT_CLK_NR(reset_clears, clock, reset |=> rsp_empty && !req_full)

   // an error result is a lone zero that closes its item
   `ASSERT_CLK(err_shape, clock, reset, rsp_err |-> rsp_item.out_char == CharNul && rsp_item.run_end)

   // a taken percent sign is followed at once by a hex digit of the same item
   `ASSERT_CLK(pct_then_hex, clock, reset, pct_taken |=> !rsp_empty && hex_shown && !rsp_item.run_end)

endmodule

bind utf16_to_utf8_percent_encoder utf8pe_checker u_checker (.*);

[sim/utf16_to_utf8_percent_encoder_tb.sv]
`timescale 1ns / 1ps

module utf16_to_utf8_percent_encoder_tb;
   import utf8pe_pkg::*;

   // cycles with no handshake on either side before the run is declared hung
   localparam int StallLimit    = 4000;
   // quiet cycles after the last expected result, covers items that give no result
   localparam int DrainCycles   = 30;
   // random units per phase, with the directed units about 230 in all
   localparam int UnitsPerPhase = 68;

   // expected output characters of the encoder, built from every accepted unit
   class encoder_scoreboard;
      logic [9:0]   held_high = '0;    // low ten bits of a waiting high surrogate
      bit           high_held = 1'b0;
      bit           skipping  = 1'b0;  // rest of the string is dropped
      rsp_item_type expected_chars[$];
      int           failures  = 0;

      function void push_char(logic [7:0] ch, logic err);
         rsp_item_type c;
         c.out_char = ch;
         c.is_error = err;
         c.run_end  = 1'b0;
         expected_chars.push_back(c);
      endfunction

      function logic [7:0] hex_nibble(logic [3:0] v);
         if (v < 4'd10) begin
            return 8'h30 + v;
         end
         return 8'h61 + v - 8'd10;
      endfunction

      // letters, digits and . - _ / pass as they are, the rest becomes %xx
      function void push_byte(logic [7:0] b);
         if ((b >= 8'h41 && b <= 8'h5a) || (b >= 8'h61 && b <= 8'h7a) ||
             (b >= 8'h30 && b <= 8'h39) || b == 8'h2e || b == 8'h2d ||
             b == 8'h5f || b == 8'h2f) begin
            push_char(b, 1'b0);
         end else begin
            push_char(CharPercent, 1'b0);
            push_char(hex_nibble(b[7:4]), 1'b0);
            push_char(hex_nibble(b[3:0]), 1'b0);
         end
      endfunction

      function void push_code_point(logic [20:0] cp);
         if (cp < 21'h80) begin
            push_byte(cp[7:0]);
         end else if (cp < 21'h800) begin
            push_byte({3'b110, cp[10:6]});
            push_byte({2'b10, cp[5:0]});
         end else if (cp < 21'h10000) begin
            push_byte({4'b1110, cp[15:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
         end else begin
            push_byte({5'b11110, cp[20:18]});
            push_byte({2'b10, cp[17:12]});
            push_byte({2'b10, cp[11:6]});
            push_byte({2'b10, cp[5:0]});
         end
      endfunction

      // one accepted code unit: update the string state, queue its characters
      function void note_unit(req_item_type it);
         int           n_before;
         bit           is_low;
         bit           is_high;
         rsp_item_type tail;
         n_before = expected_chars.size();
         is_low   = (it.code_unit[15:10] == 6'b110111);
         is_high  = (it.code_unit[15:10] == 6'b110110);
         if (!skipping) begin
            if (high_held) begin
               if (is_low) begin
                  push_code_point({1'b0, held_high, it.code_unit[9:0]} + 21'h10000);
               end else begin
                  push_char(CharNul, 1'b1);
                  skipping = 1'b1;
               end
               high_held = 1'b0;
               held_high = '0;
            end else if (it.code_unit == 16'h0000) begin
               skipping = 1'b1;
            end else if (is_low) begin
               push_char(CharNul, 1'b1);
               skipping = 1'b1;
            end else if (is_high) begin
               if (it.last_unit) begin
                  push_char(CharNul, 1'b1);
               end else begin
                  held_high = it.code_unit[9:0];
                  high_held = 1'b1;
               end
            end else begin
               push_code_point({5'b0, it.code_unit});
            end
         end
         if (expected_chars.size() > n_before) begin
            tail = expected_chars.pop_back();
            tail.run_end = 1'b1;
            expected_chars.push_back(tail);
         end
         if (it.last_unit) begin
            held_high = '0;
            high_held = 1'b0;
            skipping  = 1'b0;
         end
      endfunction

      function void check_char(rsp_item_type got);
         rsp_item_type want;
         if (expected_chars.size() == 0) begin
            failures++;
            if (failures <= 10) begin
               $display("unexpected result: char %h err %b end %b",
                        got.out_char, got.is_error, got.run_end);
            end
         end else begin
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.is_error !== want.is_error ||
                got.run_end !== want.run_end) begin
               failures++;
               if (failures <= 10) begin
                  $display("mismatch: expected char %h err %b end %b, got char %h err %b end %b",
                           want.out_char, want.is_error, want.run_end,
                           got.out_char, got.is_error, got.run_end);
               end
            end
         end
      endfunction
   endclass

   logic         clock;
   logic         reset;
   logic         req_push;
   req_item_type req_item;
   logic         req_full;
   logic         rsp_empty;
   logic         rsp_pop;
   rsp_item_type rsp_item;

   encoder_scoreboard sb;

   int send_idle_pct;   // chance in a hundred that the sender skips a cycle
   int rcv_idle_pct;    // same for the receiver
   int units_sent;
   int stall_cycles;

   utf16_to_utf8_percent_encoder u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_item  (req_item),
      .req_full  (req_full),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // handshakes are sampled at the rising edge, inputs only move at the falling one
   always @(posedge clock) begin
      if (!reset) begin
         if (req_push && !req_full) begin
            sb.note_unit(req_item);
         end
         if (rsp_pop && !rsp_empty) begin
            sb.check_char(rsp_item);
         end
      end
   end

   // receiver: random pop, one assignment per falling edge
   initial begin
      rsp_pop = 1'b0;
      forever begin
         @(negedge clock);
         if (!reset) begin
            rsp_pop <= ($urandom_range(99) >= rcv_idle_pct);
         end
      end
   end

   // hang detection: counts cycles with no accepted item on either side
   initial begin
      stall_cycles = 0;
      while (stall_cycles < StallLimit) begin
         @(posedge clock);
         if ((req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
            stall_cycles = 0;
         end else begin
            stall_cycles++;
         end
      end
      $display("TB_ERROR");
      $finish;
   end

   // called at a falling edge, returns at a falling edge after the item is taken
   task automatic send_unit(input logic [15:0] cu, input logic is_last);
      req_item_type it;
      it.code_unit = cu;
      it.last_unit = is_last;
      while ($urandom_range(99) < send_idle_pct) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_item <= it;
      do @(posedge clock); while (req_full);
      units_sent++;
      @(negedge clock);
   endtask

   // hold the input side low until every queued character has come out
   task automatic drain_outputs();
      req_push <= 1'b0;
      @(negedge clock);
      while (sb.expected_chars.size() != 0) begin
         @(negedge clock);
      end
   endtask

   // one string of 1 to 8 units: mostly well-formed text, some broken sequences
   task automatic send_random_string();
      int          len;
      int          k;
      int          pick;
      logic [15:0] cu;
      len = $urandom_range(1, 8);
      k = 0;
      while (k < len) begin
         pick = $urandom_range(99);
         if (pick < 30) begin
            // ascii, about half of it needs escaping
            cu = 16'($urandom_range(1, 127));
         end else if (pick < 45) begin
            // two byte utf-8
            cu = 16'($urandom_range(16'h0080, 16'h07ff));
         end else if (pick < 60) begin
            // three byte utf-8 outside the surrogate range
            if ($urandom_range(1)) begin
               cu = 16'($urandom_range(16'h0800, 16'hd7ff));
            end else begin
               cu = 16'($urandom_range(16'he000, 16'hffff));
            end
         end else if (pick < 85) begin
            // surrogate pair, the high half alone if the string ends on it
            cu = 16'($urandom_range(16'hd800, 16'hdbff));
            send_unit(cu, k == len - 1);
            k++;
            if (k == len) begin
               break;
            end
            cu = 16'($urandom_range(16'hdc00, 16'hdfff));
         end else begin
            // noise: any value, nul, lone low or lone high surrogate
            case ($urandom_range(3))
               0: cu = 16'($urandom);
               1: cu = 16'h0000;
               2: cu = 16'($urandom_range(16'hdc00, 16'hdfff));
               default: cu = 16'($urandom_range(16'hd800, 16'hdbff));
            endcase
         end
         send_unit(cu, k == len - 1);
         k++;
      end
   endtask

   initial begin
      sb = new();
      reset         = 1'b1;
      req_push      = 1'b0;
      req_item      = '0;
      send_idle_pct = 34;
      rcv_idle_pct  = 79;
      units_sent    = 0;
      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // literals at the edges of the safe set, then escapes and every utf-8 length
      send_unit(16'h0041, 1'b0);
      send_unit(16'h007a, 1'b0);
      send_unit(16'h0039, 1'b0);
      send_unit(16'h002e, 1'b0);
      send_unit(16'h002d, 1'b0);
      send_unit(16'h005f, 1'b0);
      send_unit(16'h002f, 1'b0);
      send_unit(16'h0020, 1'b0);
      send_unit(16'h007f, 1'b0);
      send_unit(16'h0080, 1'b0);
      send_unit(16'h07ff, 1'b0);
      send_unit(16'h0800, 1'b0);
      send_unit(16'hffff, 1'b0);
      // smallest and largest supplementary code points, the last one is 12 chars
      send_unit(16'hd800, 1'b0);
      send_unit(16'hdc00, 1'b0);
      send_unit(16'hdbff, 1'b0);
      send_unit(16'hdfff, 1'b1);
      // lone low surrogate, then the rest of the string is dropped
      send_unit(16'hdc00, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0041, 1'b1);
      // high surrogate followed by a plain unit
      send_unit(16'hd83d, 1'b0);
      send_unit(16'h0041, 1'b0);
      send_unit(16'h0042, 1'b1);
      // high surrogate as the final unit
      send_unit(16'hdbff, 1'b1);
      // nul ends the useful part of the string
      send_unit(16'h0000, 1'b0);
      send_unit(16'h0041, 1'b1);

      // phase one: slow receiver
      while (units_sent < 26 + UnitsPerPhase) begin
         send_random_string();
      end

      // sender holds off until the output side is empty
      drain_outputs();

      // phase two: slow sender
      send_idle_pct = 79;
      rcv_idle_pct  = 34;
      while (units_sent < 26 + 2 * UnitsPerPhase) begin
         send_random_string();
      end

      // phase three: both sides at full rate
      send_idle_pct = 0;
      rcv_idle_pct  = 0;
      while (units_sent < 26 + 3 * UnitsPerPhase) begin
         send_random_string();
      end

      drain_outputs();
      repeat (DrainCycles) @(negedge clock);

      if (sb.failures == 0 && sb.expected_chars.size() == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
